/* rtl/core/tcsa_pkg.sv */
package tcsa_pkg;

   // history depth of the moving average, 1 to 16
   localparam int HISTORY_DEPTH = 4;

   localparam int RAW_W  = 12;
   localparam int SIZE_W = 11;
   localparam int POS_W  = 10;
   localparam int WORD_W = 16;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 12;

   localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
   localparam int HIST_IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int SUM_W = POS_W + $clog2(HISTORY_DEPTH);

   // shared divider: raw offset times size over raw range, and history sums over fill count
   localparam int DIV_N_W = RAW_W + SIZE_W;
   localparam int DIV_D_W = RAW_W;
   localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

   localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_X_RAW_MIN     = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_X_RAW_MAX     = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_Y_RAW_MIN     = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_Y_RAW_MAX     = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_SCREEN_WIDTH  = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_SCREEN_HEIGHT = 3'd5;

   localparam logic [RAW_W-1:0]  RAW_MIN_RESET = 12'd200;
   localparam logic [RAW_W-1:0]  RAW_MAX_RESET = 12'd3900;
   localparam logic [SIZE_W-1:0] WIDTH_RESET   = 11'd320;
   localparam logic [SIZE_W-1:0] HEIGHT_RESET  = 11'd240;

   typedef struct packed {
      logic               start;
      logic [DIV_N_W-1:0] dividend;
      logic [DIV_D_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [DIV_N_W-1:0] quotient;
   } div_rsp_type;

endpackage

/* rtl/core/tcsa_div.sv */
module tcsa_div (
   input  logic                 clock,
   input  logic                 reset,
   input  tcsa_pkg::div_req_type div_req,
   output tcsa_pkg::div_rsp_type div_rsp
);

   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [tcsa_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [tcsa_pkg::DIV_D_W-1:0]     rem_ff, rem_in;
   logic [tcsa_pkg::DIV_N_W-1:0]     quo_ff, quo_in;
   logic [tcsa_pkg::DIV_D_W-1:0]     dsr_ff, dsr_in;
   logic [tcsa_pkg::DIV_D_W:0]       trial;
   logic [tcsa_pkg::DIV_D_W:0]       diff;
   logic                             fits;

   // restoring division, one quotient bit per cycle
   assign trial = {rem_ff, quo_ff[tcsa_pkg::DIV_N_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = (trial >= {1'b0, dsr_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = tcsa_pkg::DIV_CNT_W'(tcsa_pkg::DIV_N_W);
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[tcsa_pkg::DIV_D_W-1:0] : trial[tcsa_pkg::DIV_D_W-1:0];
         quo_in = {quo_ff[tcsa_pkg::DIV_N_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == tcsa_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

`ifndef ASSERT_OFF
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy_ff)
      else $error("divider started while busy");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff))
      else $error("divider done without a run");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cnt_ff != '0))
      else $error("divider count underflow");
`endif

endmodule

/* rtl/core/touch_coordinate_scaler_averager.sv */
// Touch sample scaler and averager. Each request carries pen_down and the two converter
// words; one response comes back per request. While the pen is down each axis takes
// word bits 14..3, subtracts the raw minimum (floor 0), scales by screen size over raw
// range, clamps to size - 1 (also for an empty or inverted range) and saturates at 1023,
// then the point enters a shift history and the truncated mean of the filled entries is
// returned and held. A released sample clears the history count and returns the held
// point. A pen-down request runs four passes of the single shared restoring divider
// (each a start, a 23-bit quotient and a done; two for scaling, two for the averages),
// a multiply and a clamp step per axis, one history-summing step per filled entry plus
// one, a response step and an idle step. A release goes from idle to the response step.
// The block accepts one request at a time; a finished response sits in an output
// register until taken. Configuration is written through csr_we/csr_addr/csr_wdata;
// the user must write it only while the block is idle; the block does not enforce it.
module touch_coordinate_scaler_averager (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_pen_down,
   input  logic [tcsa_pkg::WORD_W-1:0]       req_x_word,
   input  logic [tcsa_pkg::WORD_W-1:0]       req_y_word,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_pressed,
   output logic [tcsa_pkg::POS_W-1:0]        rsp_pos_x,
   output logic [tcsa_pkg::POS_W-1:0]        rsp_pos_y,
   input  logic                              csr_we,
   input  logic [tcsa_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [tcsa_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MUL   = 3'd1;
   localparam logic [2:0] S_DIVS  = 3'd2;
   localparam logic [2:0] S_DIVW  = 3'd3;
   localparam logic [2:0] S_CLAMP = 3'd4;
   localparam logic [2:0] S_SUM   = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   localparam int RAW_W  = tcsa_pkg::RAW_W;
   localparam int SIZE_W = tcsa_pkg::SIZE_W;
   localparam int POS_W  = tcsa_pkg::POS_W;
   localparam int FILL_W = tcsa_pkg::FILL_W;
   localparam int SUM_W  = tcsa_pkg::SUM_W;
   localparam int N_W    = tcsa_pkg::DIV_N_W;
   localparam int D_W    = tcsa_pkg::DIV_D_W;
   localparam int IDX_W  = tcsa_pkg::HIST_IDX_W;
   localparam int DEPTH  = tcsa_pkg::HISTORY_DEPTH;

   logic [2:0]        state_ff, state_in;
   logic              ax_ff, ax_in;          // 0: X axis, 1: Y axis
   logic              avg_ff, avg_in;        // divider is doing the averages
   logic [RAW_W-1:0]  raw_x_ff, raw_x_in;
   logic [RAW_W-1:0]  raw_y_ff, raw_y_in;
   logic [N_W-1:0]    prod_ff, prod_in;
   logic [POS_W-1:0]  scaled_x_ff, scaled_x_in;
   logic [POS_W-1:0]  hist_x_ff [DEPTH];
   logic [POS_W-1:0]  hist_x_in [DEPTH];
   logic [POS_W-1:0]  hist_y_ff [DEPTH];
   logic [POS_W-1:0]  hist_y_in [DEPTH];
   logic [FILL_W-1:0] fill_count_ff, fill_count_in;
   logic [FILL_W-1:0] sum_cnt_ff, sum_cnt_in;
   logic [SUM_W-1:0]  sum_x_ff, sum_x_in;
   logic [SUM_W-1:0]  sum_y_ff, sum_y_in;
   logic [POS_W-1:0]  held_x_ff, held_x_in;
   logic [POS_W-1:0]  held_y_ff, held_y_in;
   logic              pen_ff, pen_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_pressed_ff, rsp_pressed_in;
   logic [POS_W-1:0]  rsp_pos_x_ff, rsp_pos_x_in;
   logic [POS_W-1:0]  rsp_pos_y_ff, rsp_pos_y_in;

   logic [RAW_W-1:0]  x_raw_min_ff, x_raw_min_in;
   logic [RAW_W-1:0]  x_raw_max_ff, x_raw_max_in;
   logic [RAW_W-1:0]  y_raw_min_ff, y_raw_min_in;
   logic [RAW_W-1:0]  y_raw_max_ff, y_raw_max_in;
   logic [SIZE_W-1:0] screen_width_ff, screen_width_in;
   logic [SIZE_W-1:0] screen_height_ff, screen_height_in;

   logic [RAW_W-1:0]  cur_raw, cur_min, cur_max, cur_off, cur_range;
   logic [SIZE_W-1:0] cur_size, cur_lim, clamp_v;
   logic [POS_W-1:0]  clamp_pos;
   logic              req_fire;
   logic [IDX_W-1:0]  sum_idx;

   tcsa_pkg::div_req_type div_req;
   tcsa_pkg::div_rsp_type div_rsp;

   tcsa_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign sum_idx   = sum_cnt_ff[IDX_W-1:0];

   // per-axis operand select
   assign cur_raw   = ax_ff ? raw_y_ff : raw_x_ff;
   assign cur_min   = ax_ff ? y_raw_min_ff : x_raw_min_ff;
   assign cur_max   = ax_ff ? y_raw_max_ff : x_raw_max_ff;
   assign cur_size  = ax_ff ? screen_height_ff : screen_width_ff;
   assign cur_off   = (cur_raw > cur_min) ? (cur_raw - cur_min) : '0;
   assign cur_range = cur_max - cur_min;
   assign cur_lim   = cur_size - 1'b1;

   always_comb begin
      if (cur_size == '0) begin
         clamp_v = '0;
      end else if (cur_max <= cur_min) begin
         clamp_v = cur_lim;
      end else if (div_rsp.quotient >= N_W'(cur_size)) begin
         clamp_v = cur_lim;
      end else begin
         clamp_v = div_rsp.quotient[SIZE_W-1:0];
      end
      clamp_pos = (clamp_v > SIZE_W'(tcsa_pkg::POS_MAX)) ? tcsa_pkg::POS_MAX
                                                          : clamp_v[POS_W-1:0];
   end

   always_comb begin
      div_req.start = (state_ff == S_DIVS);
      if (avg_ff) begin
         div_req.dividend = N_W'(ax_ff ? sum_y_ff : sum_x_ff);
         div_req.divisor  = D_W'(fill_count_ff);
      end else begin
         div_req.dividend = prod_ff;
         div_req.divisor  = cur_range;
      end
   end

   always_comb begin
      state_in       = state_ff;
      ax_in          = ax_ff;
      avg_in         = avg_ff;
      raw_x_in       = raw_x_ff;
      raw_y_in       = raw_y_ff;
      prod_in        = prod_ff;
      scaled_x_in    = scaled_x_ff;
      hist_x_in      = hist_x_ff;
      hist_y_in      = hist_y_ff;
      fill_count_in  = fill_count_ff;
      sum_cnt_in     = sum_cnt_ff;
      sum_x_in       = sum_x_ff;
      sum_y_in       = sum_y_ff;
      held_x_in      = held_x_ff;
      held_y_in      = held_y_ff;
      pen_in         = pen_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_pressed_in = rsp_pressed_ff;
      rsp_pos_x_in   = rsp_pos_x_ff;
      rsp_pos_y_in   = rsp_pos_y_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               pen_in   = req_pen_down;
               raw_x_in = req_x_word[RAW_W+2:3];
               raw_y_in = req_y_word[RAW_W+2:3];
               ax_in    = 1'b0;
               avg_in   = 1'b0;
               if (req_pen_down) begin
                  state_in = S_MUL;
               end else begin
                  fill_count_in = '0;
                  state_in      = S_DONE;
               end
            end
         end
         S_MUL: begin
            prod_in  = N_W'(cur_off) * N_W'(cur_size);
            state_in = S_DIVS;
         end
         S_DIVS: begin
            state_in = S_DIVW;
         end
         S_DIVW: begin
            if (div_rsp.done) begin
               if (!avg_ff) begin
                  state_in = S_CLAMP;
               end else if (!ax_ff) begin
                  held_x_in = div_rsp.quotient[POS_W-1:0];
                  ax_in     = 1'b1;
                  state_in  = S_DIVS;
               end else begin
                  held_y_in = div_rsp.quotient[POS_W-1:0];
                  state_in  = S_DONE;
               end
            end
         end
         S_CLAMP: begin
            if (!ax_ff) begin
               scaled_x_in = clamp_pos;
               ax_in       = 1'b1;
               state_in    = S_MUL;
            end else begin
               for (int i = DEPTH - 1; i > 0; i--) begin
                  hist_x_in[i] = hist_x_ff[i-1];
                  hist_y_in[i] = hist_y_ff[i-1];
               end
               hist_x_in[0] = scaled_x_ff;
               hist_y_in[0] = clamp_pos;
               if (fill_count_ff < FILL_W'(DEPTH)) begin
                  fill_count_in = fill_count_ff + 1'b1;
               end
               sum_cnt_in = '0;
               sum_x_in   = '0;
               sum_y_in   = '0;
               state_in   = S_SUM;
            end
         end
         S_SUM: begin
            if (sum_cnt_ff < fill_count_ff) begin
               sum_x_in   = sum_x_ff + SUM_W'(hist_x_ff[sum_idx]);
               sum_y_in   = sum_y_ff + SUM_W'(hist_y_ff[sum_idx]);
               sum_cnt_in = sum_cnt_ff + 1'b1;
            end else begin
               avg_in   = 1'b1;
               ax_in    = 1'b0;
               state_in = S_DIVS;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_pressed_in = pen_ff;
               rsp_pos_x_in   = held_x_ff;
               rsp_pos_y_in   = held_y_ff;
               avg_in         = 1'b0;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      x_raw_min_in     = x_raw_min_ff;
      x_raw_max_in     = x_raw_max_ff;
      y_raw_min_in     = y_raw_min_ff;
      y_raw_max_in     = y_raw_max_ff;
      screen_width_in  = screen_width_ff;
      screen_height_in = screen_height_ff;
      if (csr_we) begin
         case (csr_addr)
            tcsa_pkg::REG_X_RAW_MIN:     x_raw_min_in     = csr_wdata[RAW_W-1:0];
            tcsa_pkg::REG_X_RAW_MAX:     x_raw_max_in     = csr_wdata[RAW_W-1:0];
            tcsa_pkg::REG_Y_RAW_MIN:     y_raw_min_in     = csr_wdata[RAW_W-1:0];
            tcsa_pkg::REG_Y_RAW_MAX:     y_raw_max_in     = csr_wdata[RAW_W-1:0];
            tcsa_pkg::REG_SCREEN_WIDTH:  screen_width_in  = csr_wdata[SIZE_W-1:0];
            tcsa_pkg::REG_SCREEN_HEIGHT: screen_height_in = csr_wdata[SIZE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         ax_ff            <= 1'b0;
         avg_ff           <= 1'b0;
         fill_count_ff    <= '0;
         held_x_ff        <= '0;
         held_y_ff        <= '0;
         rsp_valid_ff     <= 1'b0;
         x_raw_min_ff     <= tcsa_pkg::RAW_MIN_RESET;
         x_raw_max_ff     <= tcsa_pkg::RAW_MAX_RESET;
         y_raw_min_ff     <= tcsa_pkg::RAW_MIN_RESET;
         y_raw_max_ff     <= tcsa_pkg::RAW_MAX_RESET;
         screen_width_ff  <= tcsa_pkg::WIDTH_RESET;
         screen_height_ff <= tcsa_pkg::HEIGHT_RESET;
      end else begin
         state_ff         <= state_in;
         ax_ff            <= ax_in;
         avg_ff           <= avg_in;
         fill_count_ff    <= fill_count_in;
         held_x_ff        <= held_x_in;
         held_y_ff        <= held_y_in;
         rsp_valid_ff     <= rsp_valid_in;
         x_raw_min_ff     <= x_raw_min_in;
         x_raw_max_ff     <= x_raw_max_in;
         y_raw_min_ff     <= y_raw_min_in;
         y_raw_max_ff     <= y_raw_max_in;
         screen_width_ff  <= screen_width_in;
         screen_height_ff <= screen_height_in;
      end
      raw_x_ff       <= raw_x_in;
      raw_y_ff       <= raw_y_in;
      prod_ff        <= prod_in;
      scaled_x_ff    <= scaled_x_in;
      hist_x_ff      <= hist_x_in;
      hist_y_ff      <= hist_y_in;
      sum_cnt_ff     <= sum_cnt_in;
      sum_x_ff       <= sum_x_in;
      sum_y_ff       <= sum_y_in;
      pen_ff         <= pen_in;
      rsp_pressed_ff <= rsp_pressed_in;
      rsp_pos_x_ff   <= rsp_pos_x_in;
      rsp_pos_y_ff   <= rsp_pos_y_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_pressed = rsp_pressed_ff;
   assign rsp_pos_x   = rsp_pos_x_ff;
   assign rsp_pos_y   = rsp_pos_y_ff;

`ifndef ASSERT_OFF
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= FILL_W'(DEPTH))
      else $error("history count above depth");
   a_release_clears: assert property (@(posedge clock) disable iff (reset)
      req_fire && !req_pen_down |=> (fill_count_ff == '0) && (state_ff == S_DONE))
      else $error("release did not clear history count");
   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_DIVW))
      else $error("divider result with no one waiting");
   a_avg_nonzero: assert property (@(posedge clock) disable iff (reset)
      div_req.start && avg_ff |-> (fill_count_ff != '0))
      else $error("average divided by empty history");
`endif

endmodule

/* bench/tb_top.sv */
module tb_top;

   localparam int ITEMS_PER_SETTING = 57;
   localparam int NUM_SETTINGS      = 9;
   localparam int HOLD_CYCLES       = 400;
   localparam int WATCHDOG_LIMIT    = 4000;
   localparam int DRAIN_CYCLES      = 150;

   typedef struct packed {
      logic                       pressed;
      logic [tcsa_pkg::POS_W-1:0] pos_x;
      logic [tcsa_pkg::POS_W-1:0] pos_y;
   } touch_point_type;

   // expected touch points, predicted from each accepted request
   class touch_scoreboard;
      logic [tcsa_pkg::RAW_W-1:0]  raw_min [2];
      logic [tcsa_pkg::RAW_W-1:0]  raw_max [2];
      logic [tcsa_pkg::SIZE_W-1:0] size [2];
      logic [tcsa_pkg::POS_W-1:0]  hist_x [tcsa_pkg::HISTORY_DEPTH];
      logic [tcsa_pkg::POS_W-1:0]  hist_y [tcsa_pkg::HISTORY_DEPTH];
      int unsigned                 fill;
      logic [tcsa_pkg::POS_W-1:0]  held_x;
      logic [tcsa_pkg::POS_W-1:0]  held_y;
      touch_point_type             expected_points [$];
      int                          mismatches;
      int                          checked;

      function new();
         raw_min[0] = tcsa_pkg::RAW_MIN_RESET;
         raw_min[1] = tcsa_pkg::RAW_MIN_RESET;
         raw_max[0] = tcsa_pkg::RAW_MAX_RESET;
         raw_max[1] = tcsa_pkg::RAW_MAX_RESET;
         size[0] = tcsa_pkg::WIDTH_RESET;
         size[1] = tcsa_pkg::HEIGHT_RESET;
         fill = 0;
         held_x = '0;
         held_y = '0;
         mismatches = 0;
         checked = 0;
      endfunction

      function void set_reg(logic [tcsa_pkg::CSR_ADDR_W-1:0] addr,
                            logic [tcsa_pkg::CSR_DATA_W-1:0] data);
         case (addr)
            tcsa_pkg::REG_X_RAW_MIN:     raw_min[0] = data[tcsa_pkg::RAW_W-1:0];
            tcsa_pkg::REG_X_RAW_MAX:     raw_max[0] = data[tcsa_pkg::RAW_W-1:0];
            tcsa_pkg::REG_Y_RAW_MIN:     raw_min[1] = data[tcsa_pkg::RAW_W-1:0];
            tcsa_pkg::REG_Y_RAW_MAX:     raw_max[1] = data[tcsa_pkg::RAW_W-1:0];
            tcsa_pkg::REG_SCREEN_WIDTH:  size[0] = data[tcsa_pkg::SIZE_W-1:0];
            tcsa_pkg::REG_SCREEN_HEIGHT: size[1] = data[tcsa_pkg::SIZE_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [tcsa_pkg::POS_W-1:0] scale_axis(logic [tcsa_pkg::WORD_W-1:0] word,
                                                      int axis);
         logic [tcsa_pkg::RAW_W-1:0] raw;
         int unsigned offset;
         int unsigned v;
         raw = word[14:3];
         offset = (raw > raw_min[axis]) ? raw - raw_min[axis] : 0;
         if (size[axis] == 0) return '0;
         if (raw_max[axis] <= raw_min[axis]) begin
            v = size[axis] - 1;
         end else begin
            v = offset * size[axis] / (raw_max[axis] - raw_min[axis]);
            if (v >= size[axis]) v = size[axis] - 1;
         end
         if (v > tcsa_pkg::POS_MAX) v = tcsa_pkg::POS_MAX;
         return v[tcsa_pkg::POS_W-1:0];
      endfunction

      function void note_request(logic pen, logic [tcsa_pkg::WORD_W-1:0] xw,
                                 logic [tcsa_pkg::WORD_W-1:0] yw);
         touch_point_type p;
         int unsigned sum_x;
         int unsigned sum_y;
         if (pen) begin
            for (int i = tcsa_pkg::HISTORY_DEPTH - 1; i > 0; i--) begin
               hist_x[i] = hist_x[i-1];
               hist_y[i] = hist_y[i-1];
            end
            hist_x[0] = scale_axis(xw, 0);
            hist_y[0] = scale_axis(yw, 1);
            if (fill < tcsa_pkg::HISTORY_DEPTH) fill++;
            sum_x = 0;
            sum_y = 0;
            for (int i = 0; i < fill; i++) begin
               sum_x += hist_x[i];
               sum_y += hist_y[i];
            end
            held_x = tcsa_pkg::POS_W'(sum_x / fill);
            held_y = tcsa_pkg::POS_W'(sum_y / fill);
         end else begin
            fill = 0;
         end
         p.pressed = pen;
         p.pos_x = held_x;
         p.pos_y = held_y;
         expected_points.push_back(p);
      endfunction

      function void flag_mismatch(string msg);
         mismatches++;
         if (mismatches <= 10) $display("mismatch at %0t: %s", $time, msg);
      endfunction

      function void check_response(logic pressed, logic [tcsa_pkg::POS_W-1:0] x,
                                   logic [tcsa_pkg::POS_W-1:0] y);
         touch_point_type want;
         if (expected_points.size() == 0) begin
            flag_mismatch($sformatf("response with none pending: pressed=%0b x=%0d y=%0d",
                                    pressed, x, y));
            return;
         end
         want = expected_points.pop_front();
         checked++;
         if (want.pressed !== pressed || want.pos_x !== x || want.pos_y !== y)
            flag_mismatch($sformatf("expected pressed=%0b x=%0d y=%0d, got pressed=%0b x=%0d y=%0d",
                                    want.pressed, want.pos_x, want.pos_y, pressed, x, y));
      endfunction

      function int pending();
         return expected_points.size();
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic                            req_pen_down = 1'b0;
   logic [tcsa_pkg::WORD_W-1:0]     req_x_word = '0;
   logic [tcsa_pkg::WORD_W-1:0]     req_y_word = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic                            rsp_pressed;
   logic [tcsa_pkg::POS_W-1:0]      rsp_pos_x;
   logic [tcsa_pkg::POS_W-1:0]      rsp_pos_y;
   logic                            csr_we = 1'b0;
   logic [tcsa_pkg::CSR_ADDR_W-1:0] csr_addr = '0;
   logic [tcsa_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   touch_scoreboard sb;
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   logic hold_req = 1'b0;
   int  stall_cycles = 0;
   int  req_count = 0;
   int  down_count = 0;

   touch_coordinate_scaler_averager dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_pen_down (req_pen_down),
      .req_x_word   (req_x_word),
      .req_y_word   (req_y_word),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_pressed  (rsp_pressed),
      .rsp_pos_x    (rsp_pos_x),
      .rsp_pos_y    (rsp_pos_y),
      .csr_we       (csr_we),
      .csr_addr     (csr_addr),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         stall_cycles = 0;
      end else begin
         if (req_valid && req_ready) begin
            sb.note_request(req_pen_down, req_x_word, req_y_word);
            req_count++;
            if (req_pen_down) down_count++;
         end
         if (rsp_valid && rsp_ready) sb.check_response(rsp_pressed, rsp_pos_x, rsp_pos_y);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles = 0;
         else stall_cycles++;
      end
   end

   initial begin : watchdog
      while (stall_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("tb: failure");
      $finish;
   end

   // response side: random backpressure, plus one long hold when asked
   initial begin : response_sink
      int   hold_left;
      logic hold_seen;
      hold_left = 0;
      hold_seen = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // valid is left high after acceptance; the next call either keeps it or drops it
   task automatic send_request(input logic pen, input logic [tcsa_pkg::WORD_W-1:0] xw,
                               input logic [tcsa_pkg::WORD_W-1:0] yw);
      int gap;
      if ($urandom_range(99) < send_idle_pct) begin
         gap = ($urandom_range(3) == 0) ? $urandom_range(20, 130) : $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pen_down <= pen;
      req_x_word <= xw;
      req_y_word <= yw;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      // let the monitor note the last accepted request before the pending count is polled
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [tcsa_pkg::CSR_ADDR_W-1:0] addr, input int value);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= tcsa_pkg::CSR_DATA_W'(value);
      sb.set_reg(addr, tcsa_pkg::CSR_DATA_W'(value));
      @(posedge clock);
   endtask

   task automatic load_settings(input int x_min, input int x_max, input int y_min,
                                input int y_max, input int width, input int height);
      write_reg(tcsa_pkg::REG_X_RAW_MIN, x_min);
      write_reg(tcsa_pkg::REG_X_RAW_MAX, x_max);
      write_reg(tcsa_pkg::REG_Y_RAW_MIN, y_min);
      write_reg(tcsa_pkg::REG_Y_RAW_MAX, y_max);
      write_reg(tcsa_pkg::REG_SCREEN_WIDTH, width);
      write_reg(tcsa_pkg::REG_SCREEN_HEIGHT, height);
      csr_we <= 1'b0;
   endtask

   // random converter word, or one aimed at the calibrated window, its edges or the raw extremes
   function automatic logic [tcsa_pkg::WORD_W-1:0] make_word(int axis);
      logic [tcsa_pkg::RAW_W-1:0] lo;
      logic [tcsa_pkg::RAW_W-1:0] hi;
      logic [tcsa_pkg::RAW_W-1:0] raw;
      lo = sb.raw_min[axis];
      hi = sb.raw_max[axis];
      if (lo > hi) begin
         raw = lo;
         lo = hi;
         hi = raw;
      end
      case ($urandom_range(3))
         0: return tcsa_pkg::WORD_W'($urandom);
         1: raw = tcsa_pkg::RAW_W'($urandom_range(hi, lo));
         2: raw = tcsa_pkg::RAW_W'(($urandom_range(1) ? lo : hi) + $urandom_range(6) - 3);
         default: raw = $urandom_range(1) ? '1 : '0;
      endcase
      return {1'($urandom_range(1)), raw, 3'($urandom_range(7))};
   endfunction

   initial begin : stimulus
      int sent;
      int burst;
      bit hold_done;
      sb = new();
      hold_done = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset calibration 200..3900 on 320 x 240
      send_request(1'b0, 16'h0000, 16'h0000);   // release before any touch
      send_request(1'b1, 16'h0000, 16'h0000);   // below raw minimum
      send_request(1'b1, 16'hFFFF, 16'hFFFF);   // bit 15 set, raw 4095 clamps
      send_request(1'b1, 16'h8000, 16'h7FF8);
      send_request(1'b1, 16'd1600, 16'd1607);   // raw exactly at minimum
      send_request(1'b1, 16'd31200, 16'd31200); // raw at maximum clamps to size - 1
      send_request(1'b1, 16'd31192, 16'd1608);
      send_request(1'b1, 16'h4000, 16'h2000);   // history wraps
      send_request(1'b1, 16'h2AAA, 16'h5555);
      send_request(1'b0, 16'hFFFF, 16'hFFFF);   // held point
      send_request(1'b0, 16'h0000, 16'h0000);
      send_request(1'b1, 16'h1234, 16'h6789);   // average restarts
      send_request(1'b1, 16'h0007, 16'h7FFF);
      send_request(1'b0, 16'h5555, 16'hAAAA);

      for (int s = 0; s < NUM_SETTINGS; s++) begin
         wait_idle();
         case (s)
            0: load_settings(200, 3900, 200, 3900, 320, 240);
            1: load_settings(0, 4095, 0, 4095, 1024, 1024);
            2: load_settings(0, 4095, 4095, 0, 1, 1);
            3: load_settings(2000, 2000, 100, 4000, 800, 600);
            4: load_settings(1000, 1001, 3000, 3010, 1024, 1);
            5: load_settings(4095, 4095, 0, 1, 640, 480);
            default: load_settings($urandom_range(4095), $urandom_range(4095),
                                   $urandom_range(4095), $urandom_range(4095),
                                   $urandom_range(1, 1024), $urandom_range(1, 1024));
         endcase
         if (s < 3) begin
            send_idle_pct = 26;
            recv_idle_pct <= 56;
         end else if (s < 6) begin
            send_idle_pct = 56;
            recv_idle_pct <= 26;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct <= 0;
         end
         sent = 0;
         while (sent < ITEMS_PER_SETTING) begin
            if ($urandom_range(99) < 85) begin
               burst = $urandom_range(1, 2 * tcsa_pkg::HISTORY_DEPTH);
               repeat (burst) begin
                  send_request(1'b1, make_word(0), make_word(1));
                  sent++;
               end
               repeat ($urandom_range(1, 2)) begin
                  send_request(1'b0, tcsa_pkg::WORD_W'($urandom),
                               tcsa_pkg::WORD_W'($urandom));
                  sent++;
               end
            end else begin
               send_request(1'($urandom_range(1)), make_word(0), make_word(1));
               sent++;
            end
            // long response hold while requests keep coming
            if (s == 1 && !hold_done && sent >= 10) begin
               hold_req <= ~hold_req;
               hold_done = 1;
            end
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("tb summary: %0d requests (%0d pen down), %0d responses checked",
               req_count, down_count, sb.checked);
      $display("tb summary: %0d calibration settings incl. extremes, %0d mismatches",
               NUM_SETTINGS + 1, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/tcsa_pkg.sv
rtl/core/tcsa_div.sv
rtl/core/touch_coordinate_scaler_averager.sv
bench/tb_top.sv
